// ===== rtl/zcfm_pkg.sv =====
// zcfm_pkg: shared types and constants of the zero-crossing frequency meter
// used by zero_crossing_frequency_meter and zcfm_checker; no dependencies

package zcfm_pkg;

    // number of periods averaged into one result
    localparam int NUM_PERIODS = 5;

    // field widths
    localparam int CODE_W = 12;
    localparam int MV_W   = 12;
    localparam int TIME_W = 32;
    localparam int HZ_W   = 20;
    localparam int FRAC_W = 8;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;
    localparam int CFG_IDX_W = 8;

    // voltage scaling: code * 3300 against mv * 4095
    localparam int LVL_W           = 27;
    localparam int FULL_SCALE_MV   = 3300;
    localparam int FULL_SCALE_CODE = 4095;

    // reciprocal 256e6 / period, quotient below 2^28
    localparam int          RECIP_W  = 28;
    localparam logic [27:0] Q8_MEGA  = 28'd256000000;
    localparam int          SUM_W    = 33;
    localparam int          IDX_W    = 5;
    localparam int          CNT_W    = 6;
    localparam int          REM_W    = (NUM_PERIODS > 1) ? $clog2(NUM_PERIODS) : 1;

    // largest frequency a result can carry
    localparam logic [19:0] FREQ_MAX_HZ = 20'd1000000;

    // register reset values
    localparam logic [11:0] MIDPOINT_RST  = 12'd2500;
    localparam logic [11:0] TOLERANCE_RST = 12'd50;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_MIDPOINT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 8'd1;

    // measurement phase
    typedef enum logic [1:0] {
        PH_LEAVE_A = 2'd0,
        PH_ARM     = 2'd1,
        PH_LEAVE_B = 2'd2,
        PH_CLOSE   = 2'd3
    } phase_t;

    // control sequencer
    typedef enum logic [2:0] {
        ST_SAMPLE,
        ST_RECIP,
        ST_ACCUM,
        ST_MEAN,
        ST_DONE
    } state_t;

endpackage

// ===== rtl/zero_crossing_frequency_meter.sv =====
// zero_crossing_frequency_meter: takes one sample a cycle while s_tready is high,
// times rising crossings with hysteresis and averages 256e6/period over NUM_PERIODS
// periods; depends on zcfm_pkg
// a sample that does not close a period leaves s_tready high; the sample that closes one
// holds s_tready low for the bit-serial reciprocal and the accumulate, and on the last
// period of a round also for the bit-serial mean by NUM_PERIODS and the load of the
// output register, longer while that register is still full
// rst_n clears control, measurement and register state asynchronously (midpoint 2500,
// tolerance 50); datapath registers have no reset and are loaded before they are read

module zero_crossing_frequency_meter
    import zcfm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // configuration write
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [MV_W-1:0]      cfg_data,
    // samples
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // adc_code[11:0], time_us[43:12], zero[47:44]
    // results
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata,   // freq_hz[19:0], freq_frac[27:20], zero[31:28]
    output logic                 m_tuser    // zero_period
);

    state_t                    state_reg, state_next;
    phase_t                    phase_reg, phase_next;
    logic [MV_W-1:0]           mid_reg, mid_next;
    logic [MV_W-1:0]           tol_reg, tol_next;
    logic [CODE_W-1:0]         prev_reg, prev_next;
    logic [TIME_W-1:0]         start_reg, start_next;
    logic [IDX_W-1:0]          idx_reg, idx_next;
    logic [SUM_W-1:0]          sum_reg, sum_next;
    logic                      zero_reg, zero_next;
    logic [CNT_W-1:0]          cnt_reg, cnt_next;
    logic [TIME_W-1:0]         divisor_reg, divisor_next;
    logic [TIME_W-1:0]         rem_reg, rem_next;
    logic [RECIP_W-1:0]        quot_reg, quot_next;
    logic [SUM_W-1:0]          mean_reg, mean_next;
    logic [REM_W-1:0]          mrem_reg, mrem_next;
    logic                      out_valid_reg, out_valid_next;
    logic [HZ_W-1:0]           out_hz_reg, out_hz_next;
    logic [FRAC_W-1:0]         out_frac_reg, out_frac_next;
    logic                      out_zero_reg, out_zero_next;

    logic [CODE_W-1:0]         code;
    logic [TIME_W-1:0]         stamp;
    logic                      s_acc;
    logic                      out_free;
    logic signed [LVL_W-1:0]   code_lvl, prev_lvl, lo_lvl, hi_lvl, mid_lvl;
    logic signed [MV_W+1:0]    lo_mv, hi_mv;
    logic                      in_band, rising, close_hit, round_end, step_last;
    logic [TIME_W-1:0]         period;
    logic [SUM_W-1:0]          sum_add;
    logic [TIME_W:0]           rem_shift;
    logic                      rem_ge;
    logic [REM_W:0]            mrem_shift;
    logic                      mrem_ge;

    assign code  = s_tdata[CODE_W-1:0];
    assign stamp = s_tdata[CODE_W+TIME_W-1:CODE_W];

    // level compares in exact scaled units
    always_comb
    begin
        lo_mv    = $signed({2'b00, mid_reg}) - $signed({2'b00, tol_reg});
        hi_mv    = $signed({2'b00, mid_reg}) + $signed({2'b00, tol_reg});
        code_lvl = $signed(LVL_W'(code) * LVL_W'(FULL_SCALE_MV));
        prev_lvl = $signed(LVL_W'(prev_reg) * LVL_W'(FULL_SCALE_MV));
        lo_lvl   = LVL_W'(lo_mv) * $signed(LVL_W'(FULL_SCALE_CODE));
        hi_lvl   = LVL_W'(hi_mv) * $signed(LVL_W'(FULL_SCALE_CODE));
        mid_lvl  = $signed(LVL_W'(mid_reg) * LVL_W'(FULL_SCALE_CODE));
        in_band  = (code_lvl > lo_lvl) && (code_lvl < hi_lvl);
        rising   = (prev_lvl < mid_lvl) && (code_lvl >= mid_lvl);
    end

    // handshake and shared conditions
    always_comb
    begin
        s_tready  = (state_reg == ST_SAMPLE);
        cfg_ready = 1'b1;
        s_acc     = s_tvalid && s_tready;
        out_free  = !out_valid_reg || m_tready;
        close_hit = s_acc && (phase_reg == PH_CLOSE) && rising;
        round_end = (idx_reg + 1'b1) == IDX_W'(NUM_PERIODS);
        step_last = (cnt_reg == CNT_W'(1));
        period    = stamp - start_reg;
        sum_add   = sum_reg + SUM_W'(quot_reg);
    end

    // one restoring step of the reciprocal and of the mean
    always_comb
    begin
        rem_shift  = {rem_reg, quot_reg[RECIP_W-1]};
        rem_ge     = rem_shift >= {1'b0, divisor_reg};
        mrem_shift = {mrem_reg, mean_reg[SUM_W-1]};
        mrem_ge    = mrem_shift >= (REM_W+1)'(NUM_PERIODS);
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_SAMPLE: if (close_hit) state_next = ST_RECIP;
            ST_RECIP:  if (step_last) state_next = ST_ACCUM;
            ST_ACCUM:  state_next = round_end ? ST_MEAN : ST_SAMPLE;
            ST_MEAN:   if (step_last) state_next = ST_DONE;
            ST_DONE:   if (out_free) state_next = ST_SAMPLE;
            default:   state_next = ST_SAMPLE;
        endcase
    end

    // datapath and register updates
    always_comb
    begin
        phase_next     = phase_reg;
        mid_next       = mid_reg;
        tol_next       = tol_reg;
        prev_next      = prev_reg;
        start_next     = start_reg;
        idx_next       = idx_reg;
        sum_next       = sum_reg;
        zero_next      = zero_reg;
        cnt_next       = cnt_reg;
        divisor_next   = divisor_reg;
        rem_next       = rem_reg;
        quot_next      = quot_reg;
        mean_next      = mean_reg;
        mrem_next      = mrem_reg;
        out_valid_next = out_valid_reg;
        out_hz_next    = out_hz_reg;
        out_frac_next  = out_frac_reg;
        out_zero_next  = out_zero_reg;

        // register writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_MIDPOINT:  mid_next = cfg_data;
                REG_TOLERANCE: tol_next = cfg_data;
                default:       ;
            endcase
        end

        // output register drains
        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            // examine one sample in the current phase
            ST_SAMPLE:
            begin
                if (s_acc)
                begin
                    prev_next = code;
                    case (phase_reg)
                        PH_LEAVE_A: if (!in_band) phase_next = PH_ARM;
                        PH_LEAVE_B: if (!in_band) phase_next = PH_CLOSE;
                        PH_ARM:
                        begin
                            if (rising)
                            begin
                                start_next = stamp;
                                phase_next = PH_LEAVE_B;
                            end
                        end
                        default:
                        begin
                            if (rising)
                            begin
                                // a zero period saturates like a period of one
                                divisor_next = (period == '0) ? TIME_W'(1) : period;
                                zero_next    = zero_reg || (period == '0);
                                rem_next     = '0;
                                quot_next    = Q8_MEGA;
                                cnt_next     = CNT_W'(RECIP_W);
                                phase_next   = PH_LEAVE_A;
                            end
                        end
                    endcase
                end
            end

            // reciprocal, one quotient bit per cycle
            ST_RECIP:
            begin
                rem_next  = rem_ge ? TIME_W'(rem_shift - {1'b0, divisor_reg})
                                   : rem_shift[TIME_W-1:0];
                quot_next = {quot_reg[RECIP_W-2:0], rem_ge};
                cnt_next  = cnt_reg - 1'b1;
            end

            // add the period's frequency, start the mean at the end of a round
            ST_ACCUM:
            begin
                if (round_end)
                begin
                    mean_next = sum_add;
                    mrem_next = '0;
                    cnt_next  = CNT_W'(SUM_W);
                    sum_next  = '0;
                    idx_next  = '0;
                end
                else
                begin
                    sum_next = sum_add;
                    idx_next = idx_reg + 1'b1;
                end
            end

            // mean by a constant, one quotient bit per cycle
            ST_MEAN:
            begin
                mrem_next = mrem_ge ? REM_W'(mrem_shift - (REM_W+1)'(NUM_PERIODS))
                                    : mrem_shift[REM_W-1:0];
                mean_next = {mean_reg[SUM_W-2:0], mrem_ge};
                cnt_next  = cnt_reg - 1'b1;
            end

            // hand the result to the output register
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_hz_next    = mean_reg[FRAC_W+HZ_W-1:FRAC_W];
                    out_frac_next  = mean_reg[FRAC_W-1:0];
                    out_zero_next  = zero_reg;
                    zero_next      = 1'b0;
                end
            end

            default: ;
        endcase
    end

    // state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_SAMPLE;
            phase_reg     <= PH_LEAVE_A;
            mid_reg       <= MIDPOINT_RST;
            tol_reg       <= TOLERANCE_RST;
            prev_reg      <= '0;
            start_reg     <= '0;
            idx_reg       <= '0;
            sum_reg       <= '0;
            zero_reg      <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            mid_reg       <= mid_next;
            tol_reg       <= tol_next;
            prev_reg      <= prev_next;
            start_reg     <= start_next;
            idx_reg       <= idx_next;
            sum_reg       <= sum_next;
            zero_reg      <= zero_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
        quot_reg     <= quot_next;
        mean_reg     <= mean_next;
        mrem_reg     <= mrem_next;
        out_hz_reg   <= out_hz_next;
        out_frac_reg <= out_frac_next;
        out_zero_reg <= out_zero_next;
    end

    // result port
    always_comb
    begin
        m_tvalid = out_valid_reg;
        m_tdata  = {{(M_TDATA_W-HZ_W-FRAC_W){1'b0}}, out_frac_reg, out_hz_reg};
        m_tuser  = out_zero_reg;
    end

endmodule

// ===== rtl/zcfm_checker.sv =====
// zcfm_checker: port-level checks of zero_crossing_frequency_meter, bound to the top level
// depends on zcfm_pkg

module zcfm_checker
    import zcfm_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 cfg_ready,
    input logic                 s_tready,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata,
    input logic                 m_tuser
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // a new result only appears while the sample side is stalled for the mean
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result appeared without a finished mean");

    // the mean never exceeds one megahertz
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[HZ_W-1:0] < FREQ_MAX_HZ) ||
                     (m_tdata[HZ_W-1:0] == FREQ_MAX_HZ &&
                      m_tdata[HZ_W+FRAC_W-1:HZ_W] == '0))
        else $error("mean above full rate");

    // pad bits of the result stay zero
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[M_TDATA_W-1:HZ_W+FRAC_W] == '0)
        else $error("result padding not zero");

    // configuration is always taken
    assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready)
        else $error("configuration port stalled");

endmodule

bind zero_crossing_frequency_meter zcfm_checker u_zcfm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_ready (cfg_ready),
    .s_tready  (s_tready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser)
);

// ===== sim/tb_zero_crossing_frequency_meter.sv =====
// tb_zero_crossing_frequency_meter: self-checking bench for the zero-crossing frequency meter
// streams timestamped samples, predicts each averaged frequency and checks the result stream
// depends on zcfm_pkg and zero_crossing_frequency_meter
`timescale 1ns / 100ps

module tb_zero_crossing_frequency_meter;
    import zcfm_pkg::*;

    // run shape
    localparam int DRAIN_CYCLES  = 100;
    localparam int HOLD_CYCLES   = 2000;
    localparam int SWEEP_PERIODS = 12;
    localparam int RESULT_TARGET = 22;
    localparam longint RUN_LIMIT_NS = 64'd10_000_000;

    // codes at the ends of the converter range
    localparam logic [CODE_W-1:0] CODE_MIN = '0;
    localparam logic [CODE_W-1:0] CODE_MAX = '1;

    // register indexes the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED    = REG_TOLERANCE + 1'b1;
    localparam logic [CFG_IDX_W-1:0] REG_INDEX_TOP = '1;

    typedef enum {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;
    typedef enum {SMP_OUT_OF_BAND, SMP_UNDER_MID, SMP_AT_OR_OVER_MID} sample_kind_t;

    typedef struct packed {
        logic [HZ_W-1:0]   hz;
        logic [FRAC_W-1:0] frac;
        logic              zero_flag;
    } freq_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [MV_W-1:0]      cfg_data = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;

    // meter state as the bench tracks it
    phase_t            meter_phase = PH_LEAVE_A;
    logic [CODE_W-1:0] last_code = '0;
    logic [TIME_W-1:0] arm_stamp = '0;
    logic [IDX_W-1:0]  periods_done = '0;
    logic [SUM_W-1:0]  q8_sum = '0;
    logic              saw_zero_period = 1'b0;
    logic [MV_W-1:0]   mid_mv = MIDPOINT_RST;
    logic [MV_W-1:0]   tol_mv = TOLERANCE_RST;

    freq_result_t expected_freqs[$];
    int unsigned  results_predicted = 0;
    int unsigned  error_count = 0;
    int unsigned  send_gap_pct = 0;
    int unsigned  recv_stall_pct = 0;
    int unsigned  hold_left = 0;

    zero_crossing_frequency_meter uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always #10 clk = ~clk;

    // level checks: code*3300 against millivolts*4095, exact
    function automatic bit under_mid(logic [CODE_W-1:0] code);
        return longint'(code) * FULL_SCALE_MV < longint'(mid_mv) * FULL_SCALE_CODE;
    endfunction

    function automatic bit outside_band(logic [CODE_W-1:0] code);
        longint c;
        longint lo_lvl;
        longint hi_lvl;
        c      = longint'(code) * FULL_SCALE_MV;
        lo_lvl = (longint'(mid_mv) - longint'(tol_mv)) * FULL_SCALE_CODE;
        hi_lvl = (longint'(mid_mv) + longint'(tol_mv)) * FULL_SCALE_CODE;
        return !(c > lo_lvl && c < hi_lvl);
    endfunction

    function automatic bit crosses_up(logic [CODE_W-1:0] prev, logic [CODE_W-1:0] code);
        return under_mid(prev) && !under_mid(code);
    endfunction

    // advance the tracked meter by one accepted sample
    function automatic void track_sample(logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp_us);
        logic [TIME_W-1:0] span;
        logic [TIME_W-1:0] recip;
        logic [SUM_W-1:0]  mean;
        freq_result_t      res;
        case (meter_phase)
            PH_LEAVE_A:
                if (outside_band(code))
                    meter_phase = PH_ARM;
            PH_LEAVE_B:
                if (outside_band(code))
                    meter_phase = PH_CLOSE;
            PH_ARM:
                if (crosses_up(last_code, code))
                begin
                    arm_stamp   = stamp_us;
                    meter_phase = PH_LEAVE_B;
                end
            default:
                if (crosses_up(last_code, code))
                begin
                    // period wraps modulo 2^32, zero saturates to 1 MHz
                    span = stamp_us - arm_stamp;
                    if (span == 0)
                    begin
                        recip           = TIME_W'(Q8_MEGA);
                        saw_zero_period = 1'b1;
                    end
                    else
                        recip = TIME_W'(Q8_MEGA) / span;
                    q8_sum       = q8_sum + SUM_W'(recip);
                    periods_done = periods_done + 1'b1;
                    meter_phase  = PH_LEAVE_A;
                    if (periods_done >= NUM_PERIODS)
                    begin
                        mean          = q8_sum / SUM_W'(NUM_PERIODS);
                        res.hz        = mean[HZ_W+FRAC_W-1:FRAC_W];
                        res.frac      = mean[FRAC_W-1:0];
                        res.zero_flag = saw_zero_period;
                        expected_freqs.push_back(res);
                        results_predicted++;
                        q8_sum          = '0;
                        periods_done    = '0;
                        saw_zero_period = 1'b0;
                    end
                end
        endcase
        last_code = code;
    endfunction

    // random code in [lo, hi], often right at the chosen edge
    function automatic logic [CODE_W-1:0] near_edge(longint lo, longint hi, bit take_hi);
        longint top;
        top = (hi > FULL_SCALE_CODE) ? FULL_SCALE_CODE : hi;
        if ($urandom_range(3) == 0)
            return CODE_W'(take_hi ? top : lo);
        return CODE_W'($urandom_range(int'(top), int'(lo)));
    endfunction

    // pick a code of the wanted kind for the current levels, random if none exists
    function automatic logic [CODE_W-1:0] code_for(sample_kind_t kind);
        longint mid_lvl;
        longint lo_lvl;
        longint hi_cut;
        longint cut;
        mid_lvl = longint'(mid_mv) * FULL_SCALE_CODE;
        lo_lvl  = (longint'(mid_mv) - longint'(tol_mv)) * FULL_SCALE_CODE;
        hi_cut  = ((longint'(mid_mv) + longint'(tol_mv)) * FULL_SCALE_CODE + FULL_SCALE_MV - 1)
                  / FULL_SCALE_MV;
        case (kind)
            SMP_UNDER_MID:
                if (mid_lvl > 0)
                    return near_edge(0, (mid_lvl - 1) / FULL_SCALE_MV, 1'b1);
            SMP_AT_OR_OVER_MID:
            begin
                cut = (mid_lvl + FULL_SCALE_MV - 1) / FULL_SCALE_MV;
                if (cut <= FULL_SCALE_CODE)
                    return near_edge(cut, FULL_SCALE_CODE, 1'b0);
            end
            default:
            begin
                if (lo_lvl >= 0 && (hi_cut > FULL_SCALE_CODE || $urandom_range(1) == 0))
                    return near_edge(0, lo_lvl / FULL_SCALE_MV, 1'b1);
                if (hi_cut <= FULL_SCALE_CODE)
                    return near_edge(hi_cut, FULL_SCALE_CODE, 1'b0);
            end
        endcase
        return CODE_W'($urandom_range(FULL_SCALE_CODE));
    endfunction

    function automatic logic [TIME_W-1:0] pick_span();
        case ($urandom_range(19))
            0:       return '0;
            1:       return TIME_W'(1);
            2:       return $urandom;
            3:       return '1;
            default: return $urandom_range(5000, 2);
        endcase
    endfunction

    task automatic set_idling(idle_mode_t mode);
        send_gap_pct   = (mode == IDLE_SENDER) ? 48 : (mode == IDLE_BOTH) ? 10 : 0;
        recv_stall_pct = (mode == IDLE_RECEIVER) ? 48 : (mode == IDLE_BOTH) ? 10 : 0;
    endtask

    // one sample transaction, predicted when accepted
    task automatic send_sample(logic [CODE_W-1:0] code, logic [TIME_W-1:0] stamp_us);
        @(negedge clk);
        while ($urandom_range(99) < send_gap_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W-TIME_W-CODE_W){1'b0}}, stamp_us, code};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        track_sample(code, stamp_us);
    endtask

    // one configuration transaction
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [MV_W-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_MIDPOINT)
            mid_mv = value;
        else if (idx == REG_TOLERANCE)
            tol_mv = value;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // stop sending, collect all results and let a silent period close finish
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_freqs.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // leave band, cross, leave band, cross; the second crossing closes the period
    task automatic send_period();
        logic [TIME_W-1:0] arm_at;
        logic [TIME_W-1:0] span;
        logic [CODE_W-1:0] code;
        arm_at = $urandom;
        span   = pick_span();
        for (int half = 0; half < 2; half++)
        begin
            code = code_for(SMP_OUT_OF_BAND);
            send_sample(code, $urandom);
            if (!under_mid(code))
                send_sample(code_for(SMP_UNDER_MID), $urandom);
            if ($urandom_range(99) < 8)
                send_sample(CODE_W'($urandom_range(FULL_SCALE_CODE)), $urandom);
            send_sample(code_for(SMP_AT_OR_OVER_MID), (half == 0) ? arm_at : arm_at + span);
        end
    endtask

    // square wave at the code extremes: zero period, wrap, widest period, period of one
    task automatic test_directed_round();
        logic [TIME_W-1:0] arm_at [5];
        logic [TIME_W-1:0] close_at [5];
        arm_at   = '{32'h0000_0100, 32'hFFFF_FFF0, 32'h0000_0000, 32'd1000, 32'h1234_5678};
        close_at = '{32'h0000_0100, 32'h0000_0010, 32'hFFFF_FFFF, 32'd1001, 32'h1234_6230};
        set_idling(IDLE_NONE);
        for (int i = 0; i < 5; i++)
        begin
            send_sample(CODE_MIN, '1);
            send_sample(CODE_MAX, arm_at[i]);
            send_sample(CODE_MIN, '0);
            send_sample(CODE_MAX, close_at[i]);
        end
    endtask

    // level settings including the range ends and a band reaching below zero
    task automatic test_register_sweep();
        int unsigned mid_list [8] = '{2500, 1650, 3300, 20, 0, 3300, 2047, 1000};
        int unsigned tol_list [8] = '{50, 0, 3300, 50, 0, 0, 100, 900};
        int unsigned extra_rounds = 0;
        for (int i = 0; i < 8; i++)
        begin
            drain();
            set_idling(idle_mode_t'(i % 4));
            if (i == 4)
            begin
                write_reg(REG_UNUSED, MV_W'($urandom_range(FULL_SCALE_CODE)));
                write_reg(REG_INDEX_TOP, MV_W'($urandom_range(FULL_SCALE_CODE)));
            end
            write_reg(REG_MIDPOINT, MV_W'(mid_list[i]));
            write_reg(REG_TOLERANCE, MV_W'(tol_list[i]));
            repeat (SWEEP_PERIODS)
                send_period();
        end
        // random levels until enough averages have been produced
        while (results_predicted < RESULT_TARGET && extra_rounds < 10)
        begin
            drain();
            set_idling(idle_mode_t'($urandom_range(3)));
            write_reg(REG_MIDPOINT, MV_W'($urandom_range(3300, 100)));
            write_reg(REG_TOLERANCE, MV_W'($urandom_range(300)));
            repeat (SWEEP_PERIODS)
                send_period();
            extra_rounds++;
        end
    endtask

    // results held back long enough for the output to fill and stall the samples
    task automatic test_output_backpressure();
        drain();
        set_idling(IDLE_NONE);
        write_reg(REG_MIDPOINT, MIDPOINT_RST);
        write_reg(REG_TOLERANCE, TOLERANCE_RST);
        hold_left = HOLD_CYCLES;
        repeat (15)
            send_period();
    endtask

    // unstructured samples over the whole code and time range
    task automatic test_random_noise();
        set_idling(IDLE_BOTH);
        repeat (40)
            send_sample(CODE_W'($urandom_range(FULL_SCALE_CODE)), $urandom);
    endtask

    // result side ready, with random stalls or a long hold
    always @(negedge clk)
    begin
        if (hold_left > 0)
        begin
            m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result transaction with the oldest prediction
    always @(posedge clk)
    begin
        freq_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_freqs.size() == 0)
            begin
                $error("freq_hz: expected no result, got %0d", m_tdata[HZ_W-1:0]);
                error_count++;
            end
            else
            begin
                want = expected_freqs.pop_front();
                if (m_tdata[HZ_W-1:0] !== want.hz)
                begin
                    $error("freq_hz: expected %0d, got %0d", want.hz, m_tdata[HZ_W-1:0]);
                    error_count++;
                end
                if (m_tdata[HZ_W+FRAC_W-1:HZ_W] !== want.frac)
                begin
                    $error("freq_frac: expected %0d, got %0d", want.frac,
                           m_tdata[HZ_W+FRAC_W-1:HZ_W]);
                    error_count++;
                end
                if (m_tuser !== want.zero_flag)
                begin
                    $error("zero_period: expected %0d, got %0d", want.zero_flag, m_tuser);
                    error_count++;
                end
                if (m_tdata[M_TDATA_W-1:HZ_W+FRAC_W] !== '0)
                begin
                    $error("m_tdata padding: expected 0, got %0h",
                           m_tdata[M_TDATA_W-1:HZ_W+FRAC_W]);
                    error_count++;
                end
            end
        end
    end

    // test sequence
    initial
    begin
        repeat (9)
            @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_round();
        test_register_sweep();
        test_output_backpressure();
        test_random_noise();
        drain();
        if (error_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // run limit
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/zcfm_pkg.sv
rtl/zero_crossing_frequency_meter.sv
rtl/zcfm_checker.sv
sim/tb_zero_crossing_frequency_meter.sv
